@@ rtl/isset_pkg.sv @@
package isset_pkg;

    localparam int CAPACITY = 16;

    localparam int OPCODE_W       = 2;
    localparam int ELEM_W         = 32;
    localparam int SLOT_INDEX_W   = 6;
    localparam int MEMBER_COUNT_W = 5;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (CNT_W > SLOT_INDEX_W) ? CNT_W : SLOT_INDEX_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_PROBE    = 2'd3
    } isset_op_t;

    typedef struct packed {
        isset_op_t                opcode;
        logic signed [ELEM_W-1:0] elem_value;
        logic [SLOT_INDEX_W-1:0]  slot_index;
    } isset_item_t;

    typedef struct packed {
        logic                      found;
        logic [MEMBER_COUNT_W-1:0] member_count;
        logic signed [ELEM_W-1:0]  slot_value;
        logic                      full_reject;
    } isset_result_t;

endpackage

@@ rtl/integer_set_store.sv @@
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    s_opcode, s_elem_value, s_slot_index
// m_       out        m_valid/m_ready    m_found, m_member_count, m_slot_value,
//                                        m_full_reject
//
// A request is registered on entry in the input register, then resolved against the store,
// and its result is registered in the core's result register and presented on m_;
// one request is taken per cycle while m_ready does not stall the pipeline.
// The rate is set by the combinational parallel compare and shift over all entries.
// Synchronous active-low reset empties the store; no clearing pass is needed.
// A stall on m_ready holds the result and backs up through the input register.
module integer_set_store (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [isset_pkg::OPCODE_W-1:0]         s_opcode,
    input  logic signed [isset_pkg::ELEM_W-1:0]    s_elem_value,
    input  logic [isset_pkg::SLOT_INDEX_W-1:0]     s_slot_index,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_found,
    output logic [isset_pkg::MEMBER_COUNT_W-1:0]   m_member_count,
    output logic signed [isset_pkg::ELEM_W-1:0]    m_slot_value,
    output logic                                   m_full_reject
);
    import isset_pkg::*;

    isset_item_t   s_item;
    isset_item_t   item;
    isset_result_t result;
    logic          item_valid;
    logic          item_ready;

    assign s_item.opcode     = isset_op_t'(s_opcode);
    assign s_item.elem_value = s_elem_value;
    assign s_item.slot_index = s_slot_index;

    isset_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    isset_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

    assign m_found        = result.found;
    assign m_member_count = result.member_count;
    assign m_slot_value   = result.slot_value;
    assign m_full_reject  = result.full_reject;

endmodule

@@ rtl/isset_in_reg.sv @@
module isset_in_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  isset_pkg::isset_item_t s_item,
    output logic                  item_valid,
    input  logic                  item_ready,
    output isset_pkg::isset_item_t item
);
    import isset_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    isset_item_t item_reg;

    assign s_ready    = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

@@ rtl/isset_core.sv @@
module isset_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  isset_pkg::isset_item_t  item,
    output logic                    m_valid,
    input  logic                    m_ready,
    output isset_pkg::isset_result_t result
);
    import isset_pkg::*;

    logic [ELEM_W-1:0]   store_reg [CAPACITY];
    logic [ELEM_W-1:0]   store_next [CAPACITY];
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                valid_reg;
    logic                valid_next;
    isset_result_t       result_reg;
    isset_result_t       result_next;

    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] at_or_after;
    logic                present;
    logic                add_wr;
    logic                rem_hit;
    logic                in_range;
    logic [ELEM_W-1:0]   probe_data;
    logic                take;

    assign item_ready = !valid_reg || m_ready;
    assign take       = item_valid && item_ready;
    assign m_valid    = valid_reg;
    assign result     = result_reg;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match[i] = (CNT_W'(i) < count_reg) && (store_reg[i] == item.elem_value);
        end
        for (int i = 0; i < CAPACITY; i++) begin
            at_or_after[i] = 1'b0;
            for (int j = 0; j <= i; j++) begin
                at_or_after[i] = at_or_after[i] | match[j];
            end
        end
        present  = |match;
        add_wr   = (item.opcode == OP_ADD) && !present && (count_reg < CNT_W'(CAPACITY));
        rem_hit  = (item.opcode == OP_REMOVE) && present;
        in_range = CMP_W'(item.slot_index) < CMP_W'(count_reg);
        probe_data = store_reg[item.slot_index[IDX_W-1:0]];

        store_next = store_reg;
        if (rem_hit) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (at_or_after[i]) begin
                    store_next[i] = store_reg[i + 1];
                end
            end
        end
        if (add_wr) begin
            store_next[count_reg[IDX_W-1:0]] = item.elem_value;
        end

        count_next = count_reg;
        if (add_wr) begin
            count_next = count_reg + CNT_W'(1);
        end else if (rem_hit) begin
            count_next = count_reg - CNT_W'(1);
        end

        result_next.member_count = MEMBER_COUNT_W'(count_next);
        result_next.full_reject  = (item.opcode == OP_ADD) && !present && !add_wr;
        if (item.opcode == OP_PROBE) begin
            result_next.slot_value = in_range ? probe_data : '0;
            result_next.found      = in_range && (probe_data == item.elem_value);
        end else begin
            result_next.slot_value = '0;
            result_next.found      = present;
        end

        valid_next = valid_reg;
        if (item_ready) begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            if (take) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            store_reg  <= store_next;
            result_reg <= result_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_reject_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && result_reg.full_reject |-> !result_reg.found)
        else $error("A refused add reports the value as present.");

    a_reject_at_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && result_reg.full_reject |->
            result_reg.member_count == MEMBER_COUNT_W'(CAPACITY))
        else $error("A refused add reports a count below capacity.");

    a_lookup_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        take && (item.opcode == OP_CONTAINS || item.opcode == OP_PROBE)
            |=> $stable(count_reg))
        else $error("A lookup request changed the entry count.");

endmodule
